// ----- sv/tle_pkg.sv -----
// Terminal line editor: shared constants, types and code points.
// Depends on nothing; every other file but tle_ram imports it.
package tle_pkg;

   localparam int LINE_LEN  = 64;
   localparam int PTR_W     = $clog2(LINE_LEN);
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 3;
   localparam int POS_W     = 6;
   localparam int NUM_REGS  = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [PTR_W-1:0]  FILL_MAX    = PTR_W'(LINE_LEN - 1);
   localparam logic [BYTE_W-1:0] SPACE_BYTE  = 8'h20;
   localparam logic [BYTE_W-1:0] STATUS_BYTE = 8'h5C;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [PTR_W-1:0]     ptr_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ESCAPE = 3'd0,
      REG_CSI    = 3'd1,
      REG_LEFT   = 3'd2,
      REG_RIGHT  = 3'd3,
      REG_ERASE  = 3'd4,
      REG_ENTER  = 3'd5
   } reg_idx_type;

   localparam byte_type REG_RESET [NUM_REGS] = '{8'd27, 8'd91, 8'd68, 8'd67, 8'd127, 8'd13};

   typedef enum logic [KIND_W-1:0] {
      KIND_FWD    = 3'd0,
      KIND_BACK   = 3'd1,
      KIND_BS     = 3'd2,
      KIND_REDRAW = 3'd3,
      KIND_FULL   = 3'd4,
      KIND_EMPTY  = 3'd5,
      KIND_CHAR   = 3'd6
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_INS_RD,
      ST_INS_WR,
      ST_EMIT_RD,
      ST_EMIT_CHK,
      ST_FLUSH
   } state_type;

endpackage

// ----- sv/tle_req_if.sv -----
// Request channel: one received terminal byte with valid/ready.
// Depends on tle_pkg.
interface tle_req_if;
   import tle_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- sv/tle_rsp_if.sv -----
// Response channel: one editor result with valid/ready.
// Depends on tle_pkg.
interface tle_rsp_if;
   import tle_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   byte_type          line_char;
   pos_type           char_pos;
   logic              last;

   modport source (output valid, output kind, output line_char, output char_pos,
                   output last, input ready);
   modport sink   (input valid, input kind, input line_char, input char_pos,
                   input last, output ready);
endinterface

// ----- sv/terminal_line_editor_top.sv -----
// Terminal line editor top level: sequencer, line RAM, register file, result register.
// Depends on tle_pkg, tle_req_if, tle_rsp_if and tle_ram.
//
//   Channel   Dir  Handshake          Payload
//   req_chan  in   valid/ready        rx_byte
//   rsp_chan  out  valid/ready        kind, line_char, char_pos, last
//   csr_*     in   csr_we (no stall)  csr_index, csr_wdata
//
// Each request is accepted, then decoded; a move, plain insert, escape or ignored byte
// ends there, and the flush state follows when a result is posted. Erase and mid-line
// insert shift each byte by a read then a write, then finish; enter reads then checks
// each stored byte, then finishes. All three are set by the line RAM: one read, then
// one write or check, per byte.
// Reset (synchronous, active high) empties the line and restores the codes;
// the line RAM needs no clearing pass as only bytes below the fill count are read.
// A stalled response holds the sequencer only when a new result must be posted.
module terminal_line_editor_top (
   input  logic                      clock,
   input  logic                      reset,
   tle_req_if.sink                   req_chan,
   tle_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  tle_pkg::csr_idx_type      csr_index,
   input  tle_pkg::byte_type         csr_wdata
);
   import tle_pkg::*;

   // control state
   state_type state_ff, state_in;
   ptr_type   fill_ff, fill_in;
   ptr_type   cursor_ff, cursor_in;
   ptr_type   idx_ff, idx_in;
   ptr_type   n_ff, n_in;            // bytes emitted so far on enter
   logic      prev_space_ff, prev_space_in;
   logic      esc_ff, esc_in;
   logic      seq_ff, seq_in;
   logic      hold_valid_ff, hold_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // payload
   byte_type  byte_ff, byte_in;
   kind_type  hold_kind_ff, hold_kind_in;
   byte_type  hold_char_ff, hold_char_in;
   ptr_type   hold_pos_ff, hold_pos_in;
   kind_type  rsp_kind_ff, rsp_kind_in;
   byte_type  rsp_char_ff, rsp_char_in;
   pos_type   rsp_pos_ff, rsp_pos_in;
   logic      rsp_last_ff, rsp_last_in;

   byte_type  cfg_ff [NUM_REGS];

   // result push into the output register
   logic      push;
   kind_type  push_kind;
   byte_type  push_char;
   ptr_type   push_pos;
   logic      push_last;
   logic      out_free;

   // line RAM
   logic      wr_en;
   ptr_type   wr_addr;
   byte_type  wr_data;
   logic      rd_en;
   ptr_type   rd_addr;
   byte_type  rd_data;

   logic      produce;
   logic      is_space;

   tle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LINE_LEN)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_space = (rd_data == SPACE_BYTE);
   // a space is kept only as the first of a run and never at the start
   assign produce  = !is_space || ((n_ff != '0) && !prev_space_ff);

   // code registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= REG_RESET[i];
         end
      end else if (csr_we && (csr_index < csr_idx_type'(NUM_REGS))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         cursor_ff     <= '0;
         idx_ff        <= '0;
         n_ff          <= '0;
         prev_space_ff <= 1'b0;
         esc_ff        <= 1'b0;
         seq_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         cursor_ff     <= cursor_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         prev_space_ff <= prev_space_in;
         esc_ff        <= esc_in;
         seq_ff        <= seq_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      hold_kind_ff <= hold_kind_in;
      hold_char_ff <= hold_char_in;
      hold_pos_ff  <= hold_pos_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      cursor_in     = cursor_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      prev_space_in = prev_space_ff;
      esc_in        = esc_ff;
      seq_in        = seq_ff;
      hold_valid_in = hold_valid_ff;
      byte_in       = byte_ff;
      hold_kind_in  = hold_kind_ff;
      hold_char_in  = hold_char_ff;
      hold_pos_in   = hold_pos_ff;
      push          = 1'b0;
      push_kind     = hold_kind_ff;
      push_char     = hold_char_ff;
      push_pos      = hold_pos_ff;
      push_last     = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               byte_in  = req_chan.rx_byte;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in     = ST_IDLE;
            hold_char_in = '0;
            if (seq_ff) begin
               seq_in = 1'b0;
               if (byte_ff == cfg_ff[REG_LEFT]) begin
                  if (cursor_ff == '0) begin
                     hold_kind_in  = KIND_FWD;
                     hold_pos_in   = cursor_ff;
                     hold_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end else begin
                     cursor_in = cursor_ff - PTR_W'(1);
                  end
               end else if (byte_ff == cfg_ff[REG_RIGHT]) begin
                  if (cursor_ff >= fill_ff) begin
                     hold_kind_in  = KIND_BACK;
                     hold_pos_in   = cursor_ff;
                     hold_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end else begin
                     cursor_in = cursor_ff + PTR_W'(1);
                  end
               end
            end else if (esc_ff && (byte_ff == cfg_ff[REG_CSI])) begin
               esc_in = 1'b0;
               seq_in = 1'b1;
            end else begin
               esc_in = 1'b0;
               if (byte_ff == cfg_ff[REG_ENTER]) begin
                  if (fill_ff != '0) begin
                     idx_in        = '0;
                     n_in          = '0;
                     prev_space_in = 1'b0;
                     hold_valid_in = 1'b0;
                     state_in      = ST_EMIT_RD;
                  end else begin
                     cursor_in = '0;
                  end
               end else if (byte_ff == cfg_ff[REG_ESCAPE]) begin
                  esc_in = 1'b1;
               end else if (byte_ff == cfg_ff[REG_ERASE]) begin
                  if (cursor_ff != '0) begin
                     idx_in   = cursor_ff - PTR_W'(1);
                     state_in = ST_DEL_RD;
                  end
               end else if (byte_ff == STATUS_BYTE) begin
                  state_in = ST_IDLE;
               end else if (fill_ff >= FILL_MAX) begin
                  // line full: drop the byte and start over
                  fill_in       = '0;
                  cursor_in     = '0;
                  hold_kind_in  = KIND_FULL;
                  hold_pos_in   = '0;
                  hold_valid_in = 1'b1;
                  state_in      = ST_FLUSH;
               end else if (cursor_ff < fill_ff) begin
                  idx_in   = fill_ff;
                  state_in = ST_INS_RD;
               end else begin
                  wr_en     = 1'b1;
                  wr_addr   = fill_ff;
                  wr_data   = byte_ff;
                  fill_in   = fill_ff + PTR_W'(1);
                  cursor_in = fill_ff + PTR_W'(1);
               end
            end
         end

         // erase: pull the tail left one place at a time
         ST_DEL_RD: begin
            if (({1'b0, idx_ff} + (PTR_W+1)'(1)) < {1'b0, fill_ff}) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff + PTR_W'(1);
               state_in = ST_DEL_WR;
            end else begin
               fill_in       = fill_ff - PTR_W'(1);
               cursor_in     = cursor_ff - PTR_W'(1);
               hold_kind_in  = KIND_BS;
               hold_char_in  = '0;
               hold_pos_in   = cursor_ff - PTR_W'(1);
               hold_valid_in = 1'b1;
               state_in      = ST_FLUSH;
            end
         end

         ST_DEL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data;
            idx_in   = idx_ff + PTR_W'(1);
            state_in = ST_DEL_RD;
         end

         // mid-line insert: push the tail right from the end, then drop the byte in
         ST_INS_RD: begin
            if (idx_ff > cursor_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff - PTR_W'(1);
               state_in = ST_INS_WR;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = cursor_ff;
               wr_data       = byte_ff;
               cursor_in     = cursor_ff + PTR_W'(1);
               fill_in       = fill_ff + PTR_W'(1);
               hold_kind_in  = KIND_REDRAW;
               hold_char_in  = '0;
               hold_pos_in   = cursor_ff + PTR_W'(1);
               hold_valid_in = 1'b1;
               state_in      = ST_FLUSH;
            end
         end

         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data;
            idx_in   = idx_ff - PTR_W'(1);
            state_in = ST_INS_RD;
         end

         // enter: walk the line; one result is held back so the final one gets last
         ST_EMIT_RD: begin
            if (idx_ff < fill_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff;
               state_in = ST_EMIT_CHK;
            end else begin
               if (!hold_valid_ff) begin
                  hold_kind_in  = KIND_EMPTY;
                  hold_char_in  = '0;
                  hold_pos_in   = '0;
                  hold_valid_in = 1'b1;
               end
               fill_in   = '0;
               cursor_in = '0;
               state_in  = ST_FLUSH;
            end
         end

         ST_EMIT_CHK: begin
            if (!(produce && hold_valid_ff && !out_free)) begin
               if (produce) begin
                  push          = hold_valid_ff;
                  push_last     = 1'b0;
                  hold_kind_in  = KIND_CHAR;
                  hold_char_in  = rd_data;
                  hold_pos_in   = n_ff;
                  hold_valid_in = 1'b1;
                  n_in          = n_ff + PTR_W'(1);
               end
               prev_space_in = is_space;
               idx_in        = idx_ff + PTR_W'(1);
               state_in      = ST_EMIT_RD;
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = push_kind;
         rsp_char_in  = push_char;
         rsp_pos_in   = POS_W'(push_pos);
         rsp_last_in  = push_last;
      end
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.kind      = rsp_kind_ff;
   assign rsp_chan.line_char = rsp_char_ff;
   assign rsp_chan.char_pos  = rsp_pos_ff;
   assign rsp_chan.last      = rsp_last_ff;

   // the cursor never passes the end of the line
   assert property (@(posedge clock) disable iff (reset) cursor_ff <= fill_ff)
      else $error("cursor beyond fill count");

   // the line never exceeds its capacity less one
   assert property (@(posedge clock) disable iff (reset) fill_ff <= FILL_MAX)
      else $error("fill count beyond line capacity");

   // no result may be pending when a new byte is taken
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("held result left behind in idle");

   // a result is only pushed into a free output register
   assert property (@(posedge clock) disable iff (reset) push |-> out_free)
      else $error("result pushed over an unconsumed one");

   // a flushed result always ends the request with last set
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final result without last");
endmodule

// ----- sv/tle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
